@@ sv/csvt_pkg.sv @@
package csvt_pkg;

    // Configuration register indexes.
    localparam logic REG_DELIM_A = 1'b0;
    localparam logic REG_DELIM_B = 1'b1;

    localparam logic [7:0] DELIM_A_RESET = 8'd32;
    localparam logic [7:0] DELIM_B_RESET = 8'd9;

    // Characters with a fixed meaning in the text.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] out_byte;
        logic       line_end;
        logic [7:0] field_count;
        logic       count_mismatch;
        logic       end_of_data;
    } t_out_item;

endpackage

@@ sv/csvt_in_if.sv @@
interface csvt_in_if
    import csvt_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ sv/csvt_out_if.sv @@
interface csvt_out_if
    import csvt_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ sv/csv_line_tokenizer_core.sv @@
// Channel     Direction  Port       Carries
// text in     sink       i_in_ch    text_byte, end_of_input
// result out  source     o_out_ch   byte_valid, out_byte, line_end, field_count,
//                                   count_mismatch, end_of_data
// config      write      i_cfg_*    delimiter_a (index 0), delimiter_b (index 1)
//
// One item per cycle sustained while the output register is not stalled. An item
// is parsed against the line state while it sits in the input register, and its
// result (if any) is loaded into the output register as the item leaves it.
// Synchronous active-low reset clears the parser flags (the last-byte-was-terminator
// flag is set), the learned field count and both valid bits, and restores the
// default delimiters.
// A stalled output register holds its result; the input register still takes an
// item while it is empty, and otherwise only when the output register is empty or
// being drained.
module csv_line_tokenizer_core
    import csvt_pkg::*;
#(
    parameter int unsigned MAX_FIELDS = 255
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    csvt_in_if.sink    i_in_ch,
    csvt_out_if.source o_out_ch
);

    // The counter is eight bits wide, so the cap never exceeds 255.
    localparam logic [7:0] FIELD_CAP = (MAX_FIELDS > 255) ? 8'd255 : 8'(MAX_FIELDS);

    logic [7:0] r_delim_a;
    logic [7:0] r_delim_b;

    logic       r_in_comment, n_in_comment;
    logic       r_after_bs,   n_after_bs;
    logic       r_in_quotes,  n_in_quotes;
    logic       r_last_term,  n_last_term;
    logic       r_line_bytes, n_line_bytes;
    logic [7:0] r_line_fields, n_line_fields;
    logic [7:0] r_expected,    n_expected;

    logic       r_s1_valid;
    t_in_item   r_s1_item;
    logic       r_out_valid;
    t_out_item  r_out;

    logic       out_load_ok;
    logic       s1_fire;
    logic       res_valid;
    t_out_item  res;

    assign out_load_ok    = !r_out_valid || o_out_ch.ready;
    assign s1_fire        = r_s1_valid && out_load_ok;
    assign i_in_ch.ready  = !r_s1_valid || out_load_ok;
    assign o_out_ch.valid = r_out_valid;
    assign o_out_ch.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim_a <= DELIM_A_RESET;
            r_delim_b <= DELIM_B_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DELIM_A: r_delim_a <= i_cfg_data;
                REG_DELIM_B: r_delim_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Parse one item against the line state.
    always_comb begin
        logic [7:0] c;
        logic       do_store;
        logic [7:0] store_val;
        logic       do_close;
        logic       is_delim;

        c         = r_s1_item.text_byte;
        do_store  = 1'b0;
        store_val = CH_NUL;
        do_close  = 1'b0;
        is_delim  = (c == CH_NUL) || (c == r_delim_a) || (c == r_delim_b);

        n_in_comment  = r_in_comment;
        n_after_bs    = r_after_bs;
        n_in_quotes   = r_in_quotes;
        n_last_term   = r_last_term;
        n_line_bytes  = r_line_bytes;
        n_line_fields = r_line_fields;
        n_expected    = r_expected;
        res           = '0;

        priority if (r_s1_item.end_of_input) begin
            if (!r_line_bytes) begin
                n_in_comment    = 1'b0;
                n_after_bs      = 1'b0;
                n_in_quotes     = 1'b0;
                res.end_of_data = 1'b1;
            end else begin
                // A pending line always gets a closing terminator here.
                do_store = 1'b1;
                do_close = 1'b1;
            end
        end else if (r_in_comment && c != CH_LF) begin
            // Comment text is dropped.
        end else if (r_after_bs) begin
            n_after_bs = 1'b0;
            do_store   = 1'b1;
            store_val  = c;
        end else if (r_in_quotes) begin
            n_in_quotes = (c != CH_QUOTE);
            do_store    = 1'b1;
            store_val   = c;
        end else if (is_delim) begin
            do_store = !r_last_term;
        end else if (c == CH_HASH) begin
            n_in_comment = 1'b1;
        end else if (c == CH_BSLASH) begin
            n_after_bs = 1'b1;
            do_store   = 1'b1;
            store_val  = c;
        end else if (c == CH_QUOTE) begin
            n_in_quotes = 1'b1;
            do_store    = 1'b1;
            store_val   = c;
        end else if (c == CH_CR || c == CH_LF) begin
            n_in_comment = 1'b0;
            if (r_line_bytes) begin
                do_store = !r_last_term;
                do_close = 1'b1;
            end
        end else begin
            do_store  = 1'b1;
            store_val = c;
        end

        if (do_store) begin
            n_line_bytes   = 1'b1;
            n_last_term    = (store_val == CH_NUL);
            res.byte_valid = 1'b1;
            res.out_byte   = store_val;
            if (store_val == CH_NUL && r_line_fields < FIELD_CAP) begin
                n_line_fields = r_line_fields + 8'd1;
            end
        end

        if (do_close) begin
            res.line_end    = 1'b1;
            res.field_count = n_line_fields;
            if (r_expected == 8'd0) begin
                n_expected = n_line_fields;
            end else begin
                res.count_mismatch = (r_expected != n_line_fields);
            end
            n_in_comment  = 1'b0;
            n_after_bs    = 1'b0;
            n_in_quotes   = 1'b0;
            n_line_bytes  = 1'b0;
            n_line_fields = 8'd0;
        end

        res_valid = do_store || do_close || res.end_of_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_in_comment  <= 1'b0;
            r_after_bs    <= 1'b0;
            r_in_quotes   <= 1'b0;
            r_last_term   <= 1'b1;
            r_line_bytes  <= 1'b0;
            r_line_fields <= 8'd0;
            r_expected    <= 8'd0;
        end else begin
            if (i_in_ch.ready) begin
                r_s1_valid <= i_in_ch.valid;
            end
            if (out_load_ok) begin
                r_out_valid <= s1_fire && res_valid;
            end
            if (s1_fire) begin
                r_in_comment  <= n_in_comment;
                r_after_bs    <= n_after_bs;
                r_in_quotes   <= n_in_quotes;
                r_last_term   <= n_last_term;
                r_line_bytes  <= n_line_bytes;
                r_line_fields <= n_line_fields;
                r_expected    <= n_expected;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_ch.ready && i_in_ch.valid) begin
            r_s1_item <= i_in_ch.data;
        end
        if (out_load_ok) begin
            r_out <= res;
        end
    end

    // A line whose last stored byte was not a terminator must have stored bytes.
    a_term_implies_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_last_term |-> r_line_bytes)
        else $error("open field without line bytes");

    // Every closed line carries at least the terminator that closed it.
    a_close_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.line_end |-> r_out.field_count != 8'd0)
        else $error("closed line reports zero fields");

    a_eod_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.end_of_data |-> !r_out.byte_valid && !r_out.line_end)
        else $error("end of data combined with other result");

    // An escape can never be pending inside a comment.
    a_escape_not_in_comment: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_after_bs && r_in_comment))
        else $error("escape pending inside comment");

endmodule

@@ tb/csv_line_tokenizer_core_test.sv @@
module csv_line_tokenizer_core_test;
    import csvt_pkg::*;

    localparam int MAX_FIELDS   = 255;
    localparam int FIELD_CAP    = (MAX_FIELDS > 255) ? 255 : MAX_FIELDS;
    localparam int ITEMS_PHASE  = 120;
    localparam int NUM_PHASES   = 6;
    localparam int LONG_HOLD    = 300;
    localparam int LIMIT_CYCLES = 400000;

    localparam t_out_item NONE = '0;

    typedef struct packed {
        t_in_item  item;
        logic      typed;
        t_out_item want;
    } t_dir_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_idx;
    logic [7:0] i_cfg_data;

    csvt_in_if  in_ch ();
    csvt_out_if out_ch ();

    csv_line_tokenizer_core #(
        .MAX_FIELDS (MAX_FIELDS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch)
    );

    always #4 i_clk = ~i_clk;

    // Tokenizer state as the testbench sees it.
    logic [7:0] pr_delim_a   = DELIM_A_RESET;
    logic [7:0] pr_delim_b   = DELIM_B_RESET;
    bit         st_comment   = 1'b0;
    bit         st_escape    = 1'b0;
    bit         st_quoted    = 1'b0;
    bit         st_last_term = 1'b1;
    bit         st_line_busy = 1'b0;
    logic [7:0] st_fields    = 8'd0;
    logic [7:0] st_learned   = 8'd0;

    t_out_item pending_tokens [$];
    t_dir_row  dir_rows [0:24];

    int  errors          = 0;
    int  items_sent      = 0;
    int  results_checked = 0;
    int  lines_closed    = 0;
    int  mismatches_seen = 0;
    int  saturated_lines = 0;
    int  holds_done      = 0;
    int  cycle_count     = 0;
    bit  hold_req        = 1'b0;
    bit  tx_calm         = 1'b0;
    bit  rx_calm         = 1'b0;

    function automatic void store_field_byte(input logic [7:0] b, inout t_out_item r);
        st_line_busy = 1'b1;
        st_last_term = (b == CH_NUL);
        if (b == CH_NUL && st_fields < FIELD_CAP) begin
            st_fields = st_fields + 8'd1;
        end
        r.byte_valid = 1'b1;
        r.out_byte   = b;
    endfunction

    function automatic void close_record(inout t_out_item r);
        bit differs;
        differs = 1'b0;
        if (st_learned == 8'd0) begin
            st_learned = st_fields;
        end else if (st_learned != st_fields) begin
            differs = 1'b1;
        end
        r.line_end       = 1'b1;
        r.field_count    = st_fields;
        r.count_mismatch = differs;
        st_comment   = 1'b0;
        st_escape    = 1'b0;
        st_quoted    = 1'b0;
        st_line_busy = 1'b0;
        st_fields    = 8'd0;
    endfunction

    // Returns 1 when the item produces a result.
    function automatic bit tokenize(input t_in_item it, output t_out_item r);
        logic [7:0] c;
        c = it.text_byte;
        r = NONE;
        if (it.end_of_input) begin
            if (!st_line_busy) begin
                st_comment    = 1'b0;
                st_escape     = 1'b0;
                st_quoted     = 1'b0;
                r.end_of_data = 1'b1;
                return 1'b1;
            end
            // A pending line always gets a closing terminator here.
            store_field_byte(CH_NUL, r);
            close_record(r);
            return 1'b1;
        end
        if (st_comment && c != CH_LF) return 1'b0;
        if (st_escape) begin
            st_escape = 1'b0;
            store_field_byte(c, r);
            return 1'b1;
        end
        if (st_quoted) begin
            st_quoted = (c != CH_QUOTE);
            store_field_byte(c, r);
            return 1'b1;
        end
        if (c == CH_NUL || c == pr_delim_a || c == pr_delim_b) begin
            if (st_last_term) return 1'b0;
            store_field_byte(CH_NUL, r);
            return 1'b1;
        end
        if (c == CH_HASH) begin
            st_comment = 1'b1;
            return 1'b0;
        end
        if (c == CH_BSLASH) begin
            st_escape = 1'b1;
            store_field_byte(c, r);
            return 1'b1;
        end
        if (c == CH_QUOTE) begin
            st_quoted = 1'b1;
            store_field_byte(c, r);
            return 1'b1;
        end
        if (c == CH_CR || c == CH_LF) begin
            st_comment = 1'b0;
            if (!st_line_busy) return 1'b0;
            if (!st_last_term) store_field_byte(CH_NUL, r);
            close_record(r);
            return 1'b1;
        end
        store_field_byte(c, r);
        return 1'b1;
    endfunction

    function automatic logic [7:0] plain_char();
        case ($urandom_range(0, 2))
            0: return 8'h61 + 8'($urandom_range(0, 25));
            1: return 8'h30 + 8'($urandom_range(0, 9));
            default: return 8'h41 + 8'($urandom_range(0, 25));
        endcase
    endfunction

    function automatic logic [7:0] pick_delim();
        case ($urandom_range(0, 2))
            0: return pr_delim_a;
            1: return pr_delim_b;
            default: return CH_NUL;
        endcase
    endfunction

    task automatic offer(input t_in_item it, input bit typed, input t_out_item want);
        t_out_item predicted;
        bit        produces;
        int        gap;
        produces = tokenize(it, predicted);
        if (typed) begin
            pending_tokens.push_back(want);
        end else if (produces) begin
            pending_tokens.push_back(predicted);
        end
        if ($urandom_range(0, 63) == 0) tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            @(negedge i_clk) in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    task automatic put(input logic [7:0] b, input logic eoi = 1'b0);
        t_in_item it;
        it.text_byte    = b;
        it.end_of_input = eoi;
        offer(it, 1'b0, NONE);
    endtask

    // One record: optional leading separators, fields with plain, escaped and
    // quoted content, optional trailing separator, optional comment, then CR, LF or CR LF.
    task automatic send_line(input int nfields);
        int k;
        int j;
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 2)) put(pick_delim());
        end
        for (k = 0; k < nfields; k++) begin
            repeat ($urandom_range(1, 4)) begin
                case ($urandom_range(0, 15))
                    0: begin
                        put(CH_BSLASH);
                        put(8'($urandom_range(0, 255)));
                    end
                    1: begin
                        put(CH_QUOTE);
                        repeat ($urandom_range(0, 4)) begin
                            j = $urandom_range(0, 5);
                            put(j == 0 ? CH_LF : j == 1 ? CH_HASH :
                                j == 2 ? pick_delim() : plain_char());
                        end
                        put(CH_QUOTE);
                    end
                    default: put(plain_char());
                endcase
            end
            if (k != nfields - 1) begin
                repeat ($urandom_range(1, 3)) put(pick_delim());
            end
        end
        if ($urandom_range(0, 4) == 0) put(pick_delim());
        if ($urandom_range(0, 7) == 0) begin
            put(CH_HASH);
            repeat ($urandom_range(0, 6)) put(plain_char());
        end
        case ($urandom_range(0, 3))
            0: begin
                put(CH_CR);
                put(CH_LF);
            end
            1: put(CH_CR);
            default: put(CH_LF);
        endcase
    endtask

    // Let every expected result drain, plus the pipeline depth for items
    // that produce nothing, before touching the delimiter registers.
    task automatic settle();
        @(negedge i_clk) in_ch.valid <= 1'b0;
        while (pending_tokens.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk) i_cfg_we <= 1'b0;
        if (idx == REG_DELIM_A) begin
            pr_delim_a = val;
        end else begin
            pr_delim_b = val;
        end
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timed out with %0d results outstanding", pending_tokens.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : result_side
        t_out_item want;
        t_out_item got;
        int        stall;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
            stall = rx_calm ? 0 : $urandom_range(0, 13);
            if (hold_req) begin
                hold_req = 1'b0;
                stall    = LONG_HOLD;
                holds_done++;
            end
            if (stall > 0) begin
                @(negedge i_clk) out_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk) out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            got = out_ch.data;
            if (pending_tokens.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
            end else begin
                want = pending_tokens.pop_front();
                check_field("byte_valid", want.byte_valid, got.byte_valid);
                check_field("out_byte", want.out_byte, got.out_byte);
                check_field("line_end", want.line_end, got.line_end);
                check_field("field_count", want.field_count, got.field_count);
                check_field("count_mismatch", want.count_mismatch, got.count_mismatch);
                check_field("end_of_data", want.end_of_data, got.end_of_data);
            end
            results_checked++;
            if (got.line_end) begin
                lines_closed++;
                if (got.count_mismatch) mismatches_seen++;
                if (got.field_count == FIELD_CAP) saturated_lines++;
            end
        end
    end

    initial begin : text_side
        int p;
        int start;
        int target;
        int pick;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = REG_DELIM_A;
        i_cfg_data   = 8'd0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;

        // Directed rows: typed results where they are obvious, the rest
        // from the predictor.
        dir_rows = '{
            '{'{8'h00, 1'b1}, 1'b1, '{1'b0, 8'h00, 1'b0, 8'd0, 1'b0, 1'b1}},
            '{'{8'h20, 1'b0}, 1'b0, NONE},
            '{'{8'h61, 1'b0}, 1'b1, '{1'b1, 8'h61, 1'b0, 8'd0, 1'b0, 1'b0}},
            '{'{8'hFF, 1'b0}, 1'b1, '{1'b1, 8'hFF, 1'b0, 8'd0, 1'b0, 1'b0}},
            '{'{8'h09, 1'b0}, 1'b1, '{1'b1, 8'h00, 1'b0, 8'd0, 1'b0, 1'b0}},
            '{'{8'h20, 1'b0}, 1'b0, NONE},
            '{'{CH_NUL, 1'b0}, 1'b0, NONE},
            '{'{8'h80, 1'b0}, 1'b1, '{1'b1, 8'h80, 1'b0, 8'd0, 1'b0, 1'b0}},
            '{'{CH_NUL, 1'b0}, 1'b1, '{1'b1, 8'h00, 1'b0, 8'd0, 1'b0, 1'b0}},
            '{'{CH_BSLASH, 1'b0}, 1'b1, '{1'b1, CH_BSLASH, 1'b0, 8'd0, 1'b0, 1'b0}},
            '{'{CH_HASH, 1'b0}, 1'b1, '{1'b1, CH_HASH, 1'b0, 8'd0, 1'b0, 1'b0}},
            '{'{CH_QUOTE, 1'b0}, 1'b1, '{1'b1, CH_QUOTE, 1'b0, 8'd0, 1'b0, 1'b0}},
            '{'{CH_LF, 1'b0}, 1'b1, '{1'b1, CH_LF, 1'b0, 8'd0, 1'b0, 1'b0}},
            '{'{8'h20, 1'b0}, 1'b1, '{1'b1, 8'h20, 1'b0, 8'd0, 1'b0, 1'b0}},
            '{'{CH_QUOTE, 1'b0}, 1'b1, '{1'b1, CH_QUOTE, 1'b0, 8'd0, 1'b0, 1'b0}},
            '{'{CH_HASH, 1'b0}, 1'b0, NONE},
            '{'{8'h78, 1'b0}, 1'b0, NONE},
            '{'{CH_LF, 1'b0}, 1'b0, NONE},
            '{'{CH_CR, 1'b0}, 1'b0, NONE},
            '{'{8'h62, 1'b0}, 1'b0, NONE},
            '{'{8'h20, 1'b0}, 1'b0, NONE},
            '{'{CH_CR, 1'b0}, 1'b0, NONE},
            '{'{8'h63, 1'b0}, 1'b0, NONE},
            '{'{8'hA5, 1'b1}, 1'b0, NONE},
            '{'{8'h5A, 1'b1}, 1'b1, '{1'b0, 8'h00, 1'b0, 8'd0, 1'b0, 1'b1}}
        };

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < 25; n++) begin
            offer(dir_rows[n].item, dir_rows[n].typed, dir_rows[n].want);
        end

        for (p = 0; p < NUM_PHASES; p++) begin
            settle();
            case (p)
                1: begin
                    write_reg(REG_DELIM_A, 8'h2C);
                    write_reg(REG_DELIM_B, 8'h2C);
                end
                2: begin
                    write_reg(REG_DELIM_A, 8'h00);
                    write_reg(REG_DELIM_B, 8'hFF);
                end
                3: begin
                    write_reg(REG_DELIM_A, 8'hFF);
                    write_reg(REG_DELIM_B, 8'h00);
                end
                4: begin
                    // Separators that shadow the comment mark and the newline.
                    write_reg(REG_DELIM_A, CH_HASH);
                    write_reg(REG_DELIM_B, CH_LF);
                end
                5: begin
                    write_reg(REG_DELIM_A, 8'($urandom_range(0, 255)));
                    write_reg(REG_DELIM_B, 8'($urandom_range(0, 255)));
                end
                default: ;
            endcase
            if (p == 1 || p == 4) hold_req = 1'b1;
            target = ($urandom_range(0, 1) == 0) ? 3 : $urandom_range(1, 6);
            start  = items_sent;
            // A line long enough to saturate the field counter.
            if (p == 1) send_line(FIELD_CAP + $urandom_range(10, 30));
            while (items_sent - start < ITEMS_PHASE) begin
                pick = $urandom_range(0, 19);
                if (pick < 14) begin
                    send_line(($urandom_range(0, 6) == 0) ? $urandom_range(1, 8) : target);
                end else if (pick < 16) begin
                    put(($urandom_range(0, 1) == 0) ? CH_LF : CH_CR);
                end else if (pick < 18) begin
                    repeat ($urandom_range(1, 8)) put(8'($urandom_range(0, 255)));
                end else if (pick == 18) begin
                    put(8'($urandom_range(0, 255)), 1'b1);
                end else begin
                    // A record cut short by the end of the text.
                    repeat ($urandom_range(1, 5)) put(plain_char());
                    put(8'($urandom_range(0, 255)), 1'b1);
                end
            end
        end

        settle();
        repeat (8) @(posedge i_clk);

        $display("Sent %0d text items over %0d delimiter settings; checked %0d results.",
                 items_sent, NUM_PHASES, results_checked);
        $display("Closed %0d lines, %0d flagged mismatched, %0d saturated; %0d long holds.",
                 lines_closed, mismatches_seen, saturated_lines, holds_done);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
